// ===== sv/ilp_pkg.sv =====
// Shared types, constants and character decode for the integer literal parser.
package ilp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_WIDTH  = 8;
    localparam int DIGIT_WIDTH = 5;

    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_X     = 8'h78;

    localparam logic [DIGIT_WIDTH-1:0] NOT_A_DIGIT = 5'd16;

    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_AFTER_SIGN = 3'd1,
        PH_AFTER_ZERO = 3'd2,
        PH_AFTER_X    = 3'd3,
        PH_DIGITS     = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } t_radix;

    typedef struct packed {
        t_phase                 phase;
        logic                   negative;
        t_radix                 radix;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   error_seen;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:      PH_START,
        negative:   1'b0,
        radix:      RADIX_DEC,
        acc:        '0,
        error_seen: 1'b0
    };

    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        d = NOT_A_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = DIGIT_WIDTH'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = DIGIT_WIDTH'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = DIGIT_WIDTH'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [DIGIT_WIDTH-1:0] radix_of(input t_radix r);
        logic [DIGIT_WIDTH-1:0] v;
        case (r)
            RADIX_OCT: v = 5'd8;
            RADIX_HEX: v = 5'd16;
            default:   v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ilp_step.sv =====
// Per-character parse step: next state and the result for a final character.
module ilp_step (
    input  ilp_pkg::t_parse_state                     i_state,
    input  logic [ilp_pkg::CHAR_WIDTH-1:0]            i_char,
    input  logic                                      i_last,
    output ilp_pkg::t_parse_state                     o_state,
    output logic                                      o_ok,
    output logic signed [ilp_pkg::VALUE_WIDTH-1:0]    o_value
);
    import ilp_pkg::*;

    t_parse_state           s;
    t_radix                 radix_use;
    logic                   take;
    logic [DIGIT_WIDTH-1:0] digit;
    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] acc_fin;

    assign digit = digit_of(i_char);

    always_comb begin
        s         = i_state;
        take      = 1'b0;
        radix_use = i_state.radix;
        if (!i_state.error_seen) begin
            unique case (i_state.phase)
                PH_START, PH_AFTER_SIGN: begin
                    if (i_state.phase == PH_START && i_char == CH_MINUS) begin
                        s.negative = 1'b1;
                        s.phase    = PH_AFTER_SIGN;
                        if (i_last) begin
                            s.error_seen = 1'b1;
                        end
                    end else if (i_char == CH_ZERO) begin
                        s.phase = PH_AFTER_ZERO;
                    end else begin
                        radix_use = RADIX_DEC;
                        take      = 1'b1;
                    end
                end
                PH_AFTER_ZERO: begin
                    if (i_char == CH_X) begin
                        s.radix = RADIX_HEX;
                        s.phase = PH_AFTER_X;
                        if (i_last) begin
                            s.error_seen = 1'b1;
                        end
                    end else begin
                        radix_use = RADIX_OCT;
                        take      = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
        end

        // multiply by the radix with shifts and one add
        case (radix_use)
            RADIX_HEX: scaled = i_state.acc << 4;
            RADIX_OCT: scaled = i_state.acc << 3;
            default:   scaled = (i_state.acc << 3) + (i_state.acc << 1);
        endcase

        if (take) begin
            s.radix = radix_use;
            if (digit >= radix_of(radix_use)) begin
                s.error_seen = 1'b1;
            end else begin
                s.acc   = scaled + VALUE_WIDTH'(digit);
                s.phase = PH_DIGITS;
            end
        end

        o_ok    = !s.error_seen && (s.phase == PH_DIGITS || s.phase == PH_AFTER_ZERO);
        acc_fin = s.negative ? (~s.acc + 1'b1) : s.acc;
        o_value = o_ok ? $signed(acc_fin) : '0;
        // return to the start of a literal after its final character
        o_state = i_last ? PARSE_RESET : s;
    end

endmodule

// ===== sv/integer_literal_parser.sv =====
// Top level of the streaming C integer literal parser.
// Takes one character per request on the slave side, with tlast on the final
// character of a literal, and returns one result per literal on the master side:
// tuser[0] is the well-formed flag and tdata the signed 32-bit value (zero when
// the literal is malformed, wrapping on overflow). A character is registered,
// then decode and shift-and-add accumulate carry it into the parse state, and
// a final character's result into the result register. The block takes one
// character every cycle, except while a final character waits for the result
// slot. The result register frees the input side, so characters keep flowing
// while a result waits, until a second final character has to wait for that slot.
module integer_literal_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ilp_pkg::CHAR_WIDTH-1:0]      s_axis_tdata,   // [7:0] char_code
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ilp_pkg::VALUE_WIDTH-1:0]     m_axis_tdata,   // [31:0] value
    output logic                                m_axis_tuser    // [0] ok
);
    import ilp_pkg::*;

    logic                          r_in_valid;
    logic [CHAR_WIDTH-1:0]         r_in_char;
    logic                          r_in_last;
    t_parse_state                  r_state;
    t_parse_state                  n_state;
    logic                          r_out_valid;
    logic                          r_out_ok;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic                          n_ok;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          out_free;
    logic                          proc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    ilp_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_ok    (n_ok),
        .o_value (n_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PARSE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (proc && r_in_last) begin
            r_out_ok    <= n_ok;
            r_out_value <= n_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_ok;

    // state returns to the start of a literal after its final character
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> r_state.phase == PH_START && !r_state.error_seen
            && r_state.acc == '0)
        else $error("parse state not cleared after final character");

    // a malformed literal reports zero
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_value == '0)
        else $error("nonzero value on malformed literal");

    // error stays until the literal ends
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.error_seen && !(proc && r_in_last) |=> r_state.error_seen)
        else $error("error flag dropped within a literal");

    // a final character waits while the result slot is taken
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !m_axis_tready
            |=> r_in_valid && r_in_last && r_out_valid)
        else $error("final character lost while result stalled");

    // only a final character loads a result
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !(proc && r_in_last) |=> !r_out_valid)
        else $error("result appeared without a final character");

endmodule
